>>> hdl/wprs_pkg.sv
package wprs_pkg;

  localparam int CountBits = 16;
  localparam int DefBits   = 12;
  localparam int SumBits   = DefBits + 2;
  localparam int DefMax    = 2047;
  localparam int DefMin    = -2047;
  localparam int FullShare = 100;

  typedef logic signed [DefBits-1:0] deficit_t;
  typedef logic signed [SumBits-1:0] dsum_t;
  typedef logic [CountBits-1:0]      count_t;

  typedef enum logic [1:0] {
    CLS_H1     = 2'd0,
    CLS_H2     = 2'd1,
    CLS_H3     = 2'd2,
    CLS_SERVER = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    ROUTE_POOL  = 2'd0,
    ROUTE_OFFER = 2'd1,
    ROUTE_REUSE = 2'd2,
    ROUTE_H3    = 2'd3
  } route_t;

  typedef enum logic [0:0] {
    CFG_HTTP2_PERCENT = 1'b0,
    CFG_HTTP3_PERCENT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic   h2_conn_available;
    count_t streams;
    count_t limit;
    count_t total;
    count_t idle;
  } route_req_t;

  function automatic deficit_t sat_deficit(input dsum_t s);
    deficit_t r;
    if (s > dsum_t'(DefMax)) begin
      r = deficit_t'(DefMax);
    end else if (s < dsum_t'(DefMin)) begin
      r = deficit_t'(DefMin);
    end else begin
      r = s[DefBits-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/wprs_if.sv
interface wprs_in_if;
  logic        valid;
  logic        ready;
  logic        tunnel_forces_h1;
  logic        h2_conn_available;
  logic [15:0] h2_streams_in_use;
  logic [15:0] h2_stream_limit;
  logic [15:0] h1_total;
  logic [15:0] h1_idle;

  modport source (
    output valid, tunnel_forces_h1, h2_conn_available, h2_streams_in_use,
           h2_stream_limit, h1_total, h1_idle,
    input  ready
  );
  modport sink (
    input  valid, tunnel_forces_h1, h2_conn_available, h2_streams_in_use,
           h2_stream_limit, h1_total, h1_idle,
    output ready
  );
endinterface

interface wprs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] route;
  logic [1:0] chosen_class;

  modport source (
    output valid, route, chosen_class,
    input  ready
  );
  modport sink (
    input  valid, route, chosen_class,
    output ready
  );
endinterface

>>> hdl/wprs_deficit.sv
module wprs_deficit
  import wprs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic signed [7:0] http2_percent,
  input  logic [6:0]        http3_percent,
  output cls_t              cls
);

  deficit_t deficit_r [4];
  deficit_t deficit_nxt [4];
  deficit_t added [4];
  dsum_t    w2;
  dsum_t    w3;
  deficit_t best;
  logic [1:0] best_idx;

  assign w2 = dsum_t'(http2_percent);
  assign w3 = dsum_t'({1'b0, http3_percent});

  // weight update
  always_comb begin
    added[0] = deficit_r[0];
    added[1] = deficit_r[1];
    added[3] = deficit_r[3];
    if (http2_percent < 0) begin
      added[3] = sat_deficit(dsum_t'(deficit_r[3]) + dsum_t'(FullShare) - w3);
    end else begin
      added[0] = sat_deficit(dsum_t'(deficit_r[0]) + dsum_t'(FullShare) - w2 - w3);
      added[1] = sat_deficit(dsum_t'(deficit_r[1]) + w2);
    end
    added[2] = sat_deficit(dsum_t'(deficit_r[2]) + w3);
  end

  // largest counter, lowest index on ties
  always_comb begin
    best     = added[0];
    best_idx = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (best < added[i]) begin
        best     = added[i];
        best_idx = 2'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      deficit_nxt[i] = added[i];
    end
    deficit_nxt[best_idx] = sat_deficit(dsum_t'(best) - dsum_t'(FullShare));
  end

  assign cls = cls_t'(best_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        deficit_r[i] <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < 4; i++) begin
        deficit_r[i] <= deficit_nxt[i];
      end
    end
  end

endmodule

>>> hdl/wprs_route.sv
module wprs_route
  import wprs_pkg::*;
(
  input  cls_t       cls,
  input  route_req_t req,
  output route_t     route
);

  count_t                   inuse;
  logic [2*CountBits-1:0]   lhs;
  logic [2*CountBits-1:0]   rhs;
  logic                     idle_nz;

  assign inuse   = (req.idle > req.total) ? '0 : count_t'(req.total - req.idle);
  assign lhs     = {{CountBits{1'b0}}, req.streams} * {{CountBits{1'b0}}, req.total};
  assign rhs     = {{CountBits{1'b0}}, inuse} * {{CountBits{1'b0}}, req.limit};
  assign idle_nz = (req.idle != '0);

  always_comb begin
    case (cls)
      CLS_H1: route = ROUTE_POOL;
      CLS_H2: route = req.h2_conn_available ? ROUTE_REUSE : ROUTE_OFFER;
      CLS_H3: route = ROUTE_H3;
      CLS_SERVER: begin
        if (req.h2_conn_available && idle_nz) begin
          route = (lhs <= rhs) ? ROUTE_REUSE : ROUTE_POOL;
        end else if (req.h2_conn_available) begin
          route = ROUTE_REUSE;
        end else if (idle_nz) begin
          route = ROUTE_POOL;
        end else begin
          route = ROUTE_OFFER;
        end
      end
      default: route = ROUTE_POOL;
    endcase
  end

endmodule

>>> hdl/weighted_protocol_route_selector.sv
// pipeline: an accepted request is held in the stage-one registers, then its route and
// class move into the output registers once the output stage is free
// throughput: one request per cycle, sustained while the result side keeps up
// class pick and counter update happen at accept, the ratio compare in the next stage
// reset: counters and both percent registers clear to zero, pipeline empties
module weighted_protocol_route_selector
  import wprs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  wprs_in_if.sink    in_ch,
  wprs_out_if.source out_ch
);

  logic signed [7:0] http2_r;
  logic [6:0]        http3_r;

  logic       s1_v_r;
  cls_t       s1_cls_r;
  route_req_t s1_req_r;
  logic       out_v_r;
  route_t     route_r;
  cls_t       class_r;

  logic       accept;
  logic       s1_move;
  logic       out_free;
  cls_t       pick;
  route_t     route_nxt;
  route_req_t req_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      http2_r <= '0;
      http3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HTTP2_PERCENT: http2_r <= cfg_wdata;
        CFG_HTTP3_PERCENT: http3_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_move     = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  wprs_deficit u_deficit (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (accept),
    .http2_percent (http2_r),
    .http3_percent (http3_r),
    .cls           (pick)
  );

  always_comb begin
    req_nxt.h2_conn_available = in_ch.h2_conn_available;
    req_nxt.streams           = in_ch.h2_streams_in_use[CountBits-1:0];
    req_nxt.limit             = in_ch.h2_stream_limit[CountBits-1:0];
    req_nxt.total             = in_ch.h1_total[CountBits-1:0];
    req_nxt.idle              = in_ch.h1_idle[CountBits-1:0];
  end

  wprs_route u_route (
    .cls   (s1_cls_r),
    .req   (s1_req_r),
    .route (route_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls_r <= in_ch.tunnel_forces_h1 ? CLS_H1 : pick;
      s1_req_r <= req_nxt;
    end
    if (s1_move) begin
      route_r <= route_nxt;
      class_r <= s1_cls_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.route        = route_r;
  assign out_ch.chosen_class = class_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted request not held in stage one");

  a_h1_pool: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && class_r == CLS_H1 |-> route_r == ROUTE_POOL)
    else $error("h1 class with non-pool route");

  a_h3_route: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((class_r == CLS_H3) == (route_r == ROUTE_H3)))
    else $error("h3 route and class disagree");

  a_h2_route: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && class_r == CLS_H2 |-> route_r == ROUTE_OFFER || route_r == ROUTE_REUSE)
    else $error("h2 class with bad route");

  a_tunnel_h1: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.tunnel_forces_h1 |=> s1_cls_r == CLS_H1)
    else $error("tunnel request not forced to h1");

endmodule

>>> tb/sv/tb_weighted_protocol_route_selector.sv
module tb_weighted_protocol_route_selector;
  import wprs_pkg::*;

  localparam int RandomPhases = 12;
  localparam int PhaseItems   = 104;
  localparam int HoldAt       = 600;
  localparam int HoldCycles   = 150;
  localparam int SettleCycles = 8;

  typedef struct packed {
    logic        tunnel;
    logic        h2_avail;
    logic [15:0] streams;
    logic [15:0] limit;
    logic [15:0] total;
    logic [15:0] idle;
  } req_t;

  typedef struct packed {
    route_t route;
    cls_t   cls;
  } route_pick_t;

  typedef struct packed {
    logic       set_cfg;
    logic [7:0] h2_pct;
    logic [7:0] h3_pct;
    req_t       req;
    logic       fixed;
    route_t     exp_route;
    cls_t       exp_cls;
  } dir_row_t;

  // rows without a fixed result go through the predictor
  localparam dir_row_t DIRECTED [25] = '{
    '{1'b0, 8'h00, 8'h00, '{1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      1'b1, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'h00, 8'h00, '{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      1'b1, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'h00, 8'h00, '{1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      1'b1, ROUTE_POOL, CLS_H1},
    '{1'b1, 8'd100, 8'h00, '{1'b0, 1'b1, 16'd1, 16'd100, 16'd4, 16'd1},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'd100, 8'h00, '{1'b0, 1'b0, 16'd1, 16'd100, 16'd4, 16'd1},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'd100, 8'h00, '{1'b1, 1'b1, 16'd1, 16'd100, 16'd4, 16'd1},
      1'b1, ROUTE_POOL, CLS_H1},
    '{1'b1, 8'h00, 8'd100, '{1'b0, 1'b1, 16'd3, 16'd8, 16'd2, 16'd0},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'h00, 8'd100, '{1'b0, 1'b0, 16'd3, 16'd8, 16'd2, 16'd0},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b1, 8'hFF, 8'h00, '{1'b0, 1'b1, 16'd5, 16'd9, 16'd4, 16'd0},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b0, 1'b0, 16'd5, 16'd9, 16'd4, 16'd0},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b0, 1'b0, 16'd5, 16'd9, 16'd9, 16'd3},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b0, 1'b1, 16'd2, 16'd10, 16'd3, 16'd7},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b0, 1'b1, 16'hFFFF, 16'd1, 16'd0, 16'd5},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b0, 1'b1, 16'd0, 16'd0, 16'd9, 16'd2},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b0, 1'b1, 16'd5, 16'd0, 16'd10, 16'd2},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b0, 1'b1, 16'd2, 16'd4, 16'd4, 16'd2},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'hFF, 8'h00, '{1'b1, 1'b1, 16'd2, 16'd4, 16'd4, 16'd2},
      1'b1, ROUTE_POOL, CLS_H1},
    '{1'b1, 8'h80, 8'h7F, '{1'b0, 1'b1, 16'd7, 16'd20, 16'd12, 16'd3},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'h80, 8'h7F, '{1'b0, 1'b0, 16'd7, 16'd20, 16'd12, 16'd0},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'h80, 8'h7F, '{1'b0, 1'b1, 16'd7, 16'd20, 16'd12, 16'd12},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b1, 8'h7F, 8'h7F, '{1'b0, 1'b1, 16'h8000, 16'h0001, 16'h00FF, 16'h0080},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'h7F, 8'h7F, '{1'b0, 1'b0, 16'h7FFF, 16'hFFFE, 16'hFF00, 16'h00FF},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b1, 8'h9C, 8'h32, '{1'b0, 1'b1, 16'd1, 16'd2, 16'd6, 16'd3},
      1'b0, ROUTE_POOL, CLS_H1},
    '{1'b0, 8'h9C, 8'h32, '{1'b0, 1'b0, 16'd1, 16'd2, 16'd6, 16'd6},
      1'b0, ROUTE_POOL, CLS_H1}
  };

  localparam logic [7:0] PHASE_H2 [8] = '{8'd0, 8'd100, 8'd0, 8'hFF, 8'hFF, 8'h7F, 8'h80, 8'd50};
  localparam logic [7:0] PHASE_H3 [8] = '{8'd0, 8'd0, 8'd100, 8'd0, 8'd100, 8'h7F, 8'hFF, 8'd30};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_wdata;

  wprs_in_if  in_ch ();
  wprs_out_if out_ch ();

  weighted_protocol_route_selector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  int          h2_share;
  int          h3_share;
  int          lane_deficit [4];
  route_pick_t pending_routes [$];
  int          mismatches;
  bit          send_steady;

  function automatic int sat_lane(input int v);
    if (v > DefMax) begin
      return DefMax;
    end
    if (v < DefMin) begin
      return DefMin;
    end
    return v;
  endfunction

  task automatic predict_route(input req_t r, output route_pick_t p);
    int              pick;
    longint unsigned inuse;
    if (h2_share < 0) begin
      lane_deficit[3] = sat_lane(lane_deficit[3] + FullShare - h3_share);
    end else begin
      lane_deficit[0] = sat_lane(lane_deficit[0] + FullShare - h2_share - h3_share);
      lane_deficit[1] = sat_lane(lane_deficit[1] + h2_share);
    end
    lane_deficit[2] = sat_lane(lane_deficit[2] + h3_share);
    pick = 0;
    for (int i = 1; i < 4; i++) begin
      if (lane_deficit[pick] < lane_deficit[i]) begin
        pick = i;
      end
    end
    lane_deficit[pick] = sat_lane(lane_deficit[pick] - FullShare);
    if (r.tunnel) begin
      pick = 0;
    end
    p.cls = cls_t'(pick);
    case (p.cls)
      CLS_H1: begin
        p.route = ROUTE_POOL;
      end
      CLS_H2: begin
        p.route = r.h2_avail ? ROUTE_REUSE : ROUTE_OFFER;
      end
      CLS_H3: begin
        p.route = ROUTE_H3;
      end
      default: begin
        if (r.h2_avail && r.idle != 0) begin
          inuse = (r.idle > r.total) ? 0 : longint'(r.total) - longint'(r.idle);
          p.route = (longint'(r.streams) * longint'(r.total) <= inuse * longint'(r.limit)) ?
                    ROUTE_REUSE : ROUTE_POOL;
        end else if (r.h2_avail) begin
          p.route = ROUTE_REUSE;
        end else if (r.idle != 0) begin
          p.route = ROUTE_POOL;
        end else begin
          p.route = ROUTE_OFFER;
        end
      end
    endcase
  endtask

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 8));
      1: return 16'($urandom);
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.tunnel   = ($urandom_range(0, 7) == 0);
    r.h2_avail = 1'($urandom_range(0, 1));
    r.streams  = rand_count();
    r.limit    = rand_count();
    r.total    = rand_count();
    r.idle     = rand_count();
    return r;
  endfunction

  task automatic offer_request(input req_t r, input logic fixed, input route_pick_t fixed_pick);
    int          gap;
    route_pick_t p;
    if ($urandom_range(0, 15) == 0) begin
      send_steady = !send_steady;
    end
    gap = send_steady ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.tunnel_forces_h1  <= r.tunnel;
    in_ch.h2_conn_available <= r.h2_avail;
    in_ch.h2_streams_in_use <= r.streams;
    in_ch.h2_stream_limit   <= r.limit;
    in_ch.h1_total          <= r.total;
    in_ch.h1_idle           <= r.idle;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_route(r, p);
    if (fixed) begin
      p = fixed_pick;
    end
    pending_routes.push_back(p);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_routes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic load_shares(input logic [7:0] h2, input logic [7:0] h3);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HTTP2_PERCENT;
    cfg_wdata <= h2;
    @(posedge clk);
    cfg_index <= CFG_HTTP3_PERCENT;
    cfg_wdata <= h3;
    @(posedge clk);
    cfg_we   <= 1'b0;
    h2_share = int'($signed(h2));
    h3_share = int'(h3[6:0]);
  endtask

  initial begin
    route_pick_t fixed_pick;
    logic [7:0]  h2;
    logic [7:0]  h3;
    mismatches   = 0;
    send_steady  = 1'b0;
    h2_share     = 0;
    h3_share     = 0;
    lane_deficit = '{0, 0, 0, 0};
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_HTTP2_PERCENT;
    cfg_wdata               <= 8'h00;
    in_ch.valid             <= 1'b0;
    in_ch.tunnel_forces_h1  <= 1'b0;
    in_ch.h2_conn_available <= 1'b0;
    in_ch.h2_streams_in_use <= 16'h0000;
    in_ch.h2_stream_limit   <= 16'h0000;
    in_ch.h1_total          <= 16'h0000;
    in_ch.h1_idle           <= 16'h0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].set_cfg) begin
        drain_results();
        load_shares(DIRECTED[i].h2_pct, DIRECTED[i].h3_pct);
      end
      fixed_pick.route = DIRECTED[i].exp_route;
      fixed_pick.cls   = DIRECTED[i].exp_cls;
      offer_request(DIRECTED[i].req, DIRECTED[i].fixed, fixed_pick);
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph < 8) begin
        h2 = PHASE_H2[ph];
        h3 = PHASE_H3[ph];
      end else if ($urandom_range(0, 1)) begin
        h2 = 8'($urandom);
        h3 = 8'($urandom);
      end else begin
        h2 = 8'($urandom_range(0, 101)) - 8'd1;
        h3 = 8'($urandom_range(0, 100));
      end
      drain_results();
      load_shares(h2, h3);
      repeat (PhaseItems) offer_request(random_request(), 1'b0, fixed_pick);
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending_routes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int          gap;
    int          received;
    bit          steady;
    route_pick_t want;
    received = 0;
    steady   = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        steady = !steady;
      end
      gap = steady ? 0 : $urandom_range(0, 8);
      // long hold-off so the pipeline backs up into the request side
      if (received == HoldAt) begin
        gap = HoldCycles;
      end
      repeat (gap) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      received++;
      if (pending_routes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual route %0d class %0d",
                 $time, out_ch.route, out_ch.chosen_class);
      end else begin
        want = pending_routes.pop_front();
        if (out_ch.route !== want.route) begin
          mismatches++;
          $display("%0t: route mismatch, expected %0d, actual %0d",
                   $time, want.route, out_ch.route);
        end
        if (out_ch.chosen_class !== want.cls) begin
          mismatches++;
          $display("%0t: class mismatch, expected %0d, actual %0d",
                   $time, want.cls, out_ch.chosen_class);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
